[hdl/bfcp_pkg.sv]
package bfcp_pkg;

   // Default number of byte entries; must be a power of two
   localparam int DEPTH_DEFAULT = 256;

   localparam int OPCODE_W = 4;
   localparam int BYTE_W   = 8;

   // Operation codes
   localparam logic [OPCODE_W-1:0] OP_PUSH        = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_POP         = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_PEEK_HEAD   = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_FLUSH       = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_DRIP_START  = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_DRIP_BYTE   = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_DRIP_COMMIT = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_PEEK_START  = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_PEEK_BYTE   = 4'd8;
   localparam logic [OPCODE_W-1:0] OP_PEEK_REMOVE = 4'd9;
   localparam logic [OPCODE_W-1:0] OP_STATUS      = 4'd10;

   // Port enables from the pointer control to the byte store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_cmd_type;

endpackage

[hdl/bfcp_store.sv]
module bfcp_store
   import bfcp_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  store_cmd_type             cmd,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [BYTE_W-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [BYTE_W-1:0]         rd_data
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write port; a write is seen by reads from the next cycle on
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data follows the read enable in the next cycle
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr[ADDR_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/bfcp_ctrl.sv]
module bfcp_ctrl
   import bfcp_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [OPCODE_W-1:0]       opcode,
   input  logic [BYTE_W-1:0]         data_byte,
   output store_cmd_type             cmd,
   output logic [$clog2(DEPTH)-1:0]  wr_addr,
   output logic [BYTE_W-1:0]         wr_data,
   output logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic                      rsp_valid,
   output logic                      rsp_ok,
   output logic                      rsp_rd_sel,
   output logic [$clog2(DEPTH):0]    stored_count,
   output logic [$clog2(DEPTH):0]    dripped_count,
   output logic [$clog2(DEPTH):0]    peeked_count
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PTR_W  = ADDR_W + 1;
   localparam logic [PTR_W-1:0] FULL_DIFF = PTR_W'(DEPTH);

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] dr_ptr_ff, dr_ptr_in;
   logic [PTR_W-1:0] pk_ptr_ff, pk_ptr_in;
   logic             valid_ff, ok_ff, ok_in, rd_sel_ff, rd_sel_in;
   logic [PTR_W-1:0] stored_ff, dripped_ff, peeked_ff;
   logic [PTR_W-1:0] stored_now;

   assign stored_now = wr_ptr_ff - rd_ptr_ff;

   // Decode the request and work out the next pointers and store accesses
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      dr_ptr_in = dr_ptr_ff;
      pk_ptr_in = pk_ptr_ff;
      ok_in     = 1'b1;
      rd_sel_in = 1'b0;
      cmd       = '0;
      wr_addr   = wr_ptr_ff[ADDR_W-1:0];
      wr_data   = data_byte;
      rd_addr   = rd_ptr_ff[ADDR_W-1:0];
      if (accept) begin
         case (opcode)
            OP_PUSH: begin
               if (stored_now == FULL_DIFF) begin
                  ok_in = 1'b0;
               end else begin
                  cmd.wr_en = 1'b1;
                  wr_ptr_in = wr_ptr_ff + PTR_W'(1);
               end
            end
            OP_POP, OP_PEEK_HEAD: begin
               if (stored_now == '0) begin
                  ok_in = 1'b0;
               end else begin
                  cmd.rd_en = 1'b1;
                  rd_sel_in = 1'b1;
                  if (opcode == OP_POP) begin
                     rd_ptr_in = rd_ptr_ff + PTR_W'(1);
                  end
               end
            end
            OP_FLUSH:       rd_ptr_in = wr_ptr_ff;
            OP_DRIP_START:  dr_ptr_in = wr_ptr_ff;
            OP_DRIP_BYTE: begin
               if (PTR_W'(dr_ptr_ff - rd_ptr_ff) == FULL_DIFF) begin
                  ok_in = 1'b0;
               end else begin
                  cmd.wr_en = 1'b1;
                  wr_addr   = dr_ptr_ff[ADDR_W-1:0];
                  dr_ptr_in = dr_ptr_ff + PTR_W'(1);
               end
            end
            OP_DRIP_COMMIT: wr_ptr_in = dr_ptr_ff;
            OP_PEEK_START:  pk_ptr_in = rd_ptr_ff;
            OP_PEEK_BYTE: begin
               if (wr_ptr_ff == pk_ptr_ff) begin
                  ok_in = 1'b0;
               end else begin
                  cmd.rd_en = 1'b1;
                  rd_sel_in = 1'b1;
                  rd_addr   = pk_ptr_ff[ADDR_W-1:0];
                  pk_ptr_in = pk_ptr_ff + PTR_W'(1);
               end
            end
            OP_PEEK_REMOVE: rd_ptr_in = pk_ptr_ff;
            OP_STATUS:      ok_in = 1'b1;
            default:        ok_in = 1'b0;
         endcase
      end
   end

   // Hold pointers and the response flags
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         dr_ptr_ff <= '0;
         pk_ptr_ff <= '0;
         valid_ff  <= 1'b0;
         rd_sel_ff <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         dr_ptr_ff <= dr_ptr_in;
         pk_ptr_ff <= pk_ptr_in;
         valid_ff  <= accept;
         rd_sel_ff <= rd_sel_in;
      end
   end

   // Capture the response payload with the counts after the operation
   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff      <= ok_in;
         stored_ff  <= wr_ptr_in - rd_ptr_in;
         dripped_ff <= dr_ptr_in - wr_ptr_in;
         peeked_ff  <= pk_ptr_in - rd_ptr_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_ok        = ok_ff;
   assign rsp_rd_sel    = rd_sel_ff;
   assign stored_count  = stored_ff;
   assign dripped_count = dripped_ff;
   assign peeked_count  = peeked_ff;

   // Each accepted request gives a response on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff)
      else $error("response missing after request");

   // A push refused on a full FIFO must not touch the store
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      accept && opcode == OP_PUSH && stored_now == FULL_DIFF |-> !cmd.wr_en)
      else $error("store written on full push");

   // The stored count reported matches the pointers left behind
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> stored_ff == PTR_W'(wr_ptr_ff - rd_ptr_ff))
      else $error("stored count does not match pointers");

   // Read data is only selected for a successful read
   a_rd_ok: assert property (@(posedge clock) disable iff (reset)
      rd_sel_ff |-> valid_ff && ok_ff)
      else $error("read byte selected on failed request");

endmodule

[hdl/byte_fifo_with_commit_pointers.sv]
// The response to a request appears in the cycle after it is accepted.
// Throughput: one request per cycle; busy stays low and start is never refused.
// Pointers live in flip-flops, bytes in a single-port-write, registered-read RAM.
// Reset clears the four pointers and the response strobe; RAM contents are left.
// The receiver cannot stall: rsp_valid is high for exactly one cycle per request.
module byte_fifo_with_commit_pointers
   import bfcp_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [OPCODE_W-1:0]       req_opcode,
   input  logic [BYTE_W-1:0]         req_data_byte,
   output logic                      rsp_valid,
   output logic                      rsp_ok,
   output logic [BYTE_W-1:0]         rsp_read_byte,
   output logic [$clog2(DEPTH):0]    rsp_stored_count,
   output logic [$clog2(DEPTH):0]    rsp_dripped_count,
   output logic [$clog2(DEPTH):0]    rsp_peeked_count
);

   localparam int ADDR_W = $clog2(DEPTH);

   store_cmd_type     cmd;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [BYTE_W-1:0] wr_data, rd_data;
   logic              rd_sel;
   logic              accept;

   // Every cycle can take a request
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   bfcp_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .opcode        (req_opcode),
      .data_byte     (req_data_byte),
      .cmd           (cmd),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr       (rd_addr),
      .rsp_valid     (rsp_valid),
      .rsp_ok        (rsp_ok),
      .rsp_rd_sel    (rd_sel),
      .stored_count  (rsp_stored_count),
      .dripped_count (rsp_dripped_count),
      .peeked_count  (rsp_peeked_count)
   );

   bfcp_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .cmd     (cmd),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Drop the RAM output unless this response carries a read
   assign rsp_read_byte = rd_sel ? rd_data : '0;

endmodule

[tb/tb_byte_fifo_with_commit_pointers.sv]
module tb_byte_fifo_with_commit_pointers;
   timeunit 1ns;
   timeprecision 1ps;

   import bfcp_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int PTR_W        = $clog2(DEPTH) + 1;
   localparam int ADDR_W       = PTR_W - 1;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int MIX_REQUESTS = 160;
   localparam int DRAIN_CYCLES = 4;
   localparam int PRINT_LIMIT  = 40;

   typedef logic [PTR_W-1:0] ptr_type;

   // One response as the FIFO should report it
   typedef struct packed {
      logic              ok;
      logic [BYTE_W-1:0] read_byte;
      ptr_type           stored_count;
      ptr_type           dripped_count;
      ptr_type           peeked_count;
   } fifo_answer_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OPCODE_W-1:0] req_opcode;
   logic [BYTE_W-1:0]   req_data_byte;
   logic                rsp_valid;
   logic                rsp_ok;
   logic [BYTE_W-1:0]   rsp_read_byte;
   ptr_type             rsp_stored_count;
   ptr_type             rsp_dripped_count;
   ptr_type             rsp_peeked_count;

   // Shadow copy of the FIFO: bytes, which slots hold data, and the four pointers
   logic [BYTE_W-1:0] shadow_bytes [DEPTH];
   bit                shadow_written [DEPTH];
   ptr_type           wr_ptr   = '0;
   ptr_type           rd_ptr   = '0;
   ptr_type           drip_ptr = '0;
   ptr_type           peek_ptr = '0;

   fifo_answer_type pending_answers [$];

   int requests_sent      = 0;
   int refusals_predicted = 0;
   int responses_checked  = 0;
   int mismatch_count     = 0;
   int cycle_count        = 0;
   int burst_left         = 0;

   byte_fifo_with_commit_pointers #(
      .DEPTH(DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ok           (rsp_ok),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_stored_count (rsp_stored_count),
      .rsp_dripped_count(rsp_dripped_count),
      .rsp_peeked_count (rsp_peeked_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stop a run that hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_answers.size());
         $display("FAIL");
         $finish;
      end
   end

   // Pointer distance, wrapping at twice the depth
   function automatic ptr_type ptr_gap(input ptr_type ahead, input ptr_type behind);
      return ahead - behind;
   endfunction

   // Random byte for a request payload
   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // Apply one request to the shadow FIFO and return the response it must give
   function automatic fifo_answer_type apply_fifo_op(input logic [OPCODE_W-1:0] op,
                                                     input logic [BYTE_W-1:0]   data);
      fifo_answer_type ans;
      ans    = '0;
      ans.ok = 1'b1;
      case (op)
         OP_PUSH: begin
            if (ptr_gap(wr_ptr, rd_ptr) == DEPTH) begin
               ans.ok = 1'b0;
            end else begin
               shadow_bytes[wr_ptr[ADDR_W-1:0]]   = data;
               shadow_written[wr_ptr[ADDR_W-1:0]] = 1'b1;
               wr_ptr = wr_ptr + PTR_W'(1);
            end
         end
         OP_POP, OP_PEEK_HEAD: begin
            if (ptr_gap(wr_ptr, rd_ptr) == 0) begin
               ans.ok = 1'b0;
            end else begin
               ans.read_byte = shadow_bytes[rd_ptr[ADDR_W-1:0]];
               if (op == OP_POP) rd_ptr = rd_ptr + PTR_W'(1);
            end
         end
         OP_FLUSH:       rd_ptr   = wr_ptr;
         OP_DRIP_START:  drip_ptr = wr_ptr;
         OP_DRIP_BYTE: begin
            if (ptr_gap(drip_ptr, rd_ptr) == DEPTH) begin
               ans.ok = 1'b0;
            end else begin
               shadow_bytes[drip_ptr[ADDR_W-1:0]]   = data;
               shadow_written[drip_ptr[ADDR_W-1:0]] = 1'b1;
               drip_ptr = drip_ptr + PTR_W'(1);
            end
         end
         OP_DRIP_COMMIT: wr_ptr   = drip_ptr;
         OP_PEEK_START:  peek_ptr = rd_ptr;
         OP_PEEK_BYTE: begin
            if (ptr_gap(wr_ptr, peek_ptr) == 0) begin
               ans.ok = 1'b0;
            end else begin
               ans.read_byte = shadow_bytes[peek_ptr[ADDR_W-1:0]];
               peek_ptr = peek_ptr + PTR_W'(1);
            end
         end
         OP_PEEK_REMOVE: rd_ptr = peek_ptr;
         // status only reports the counts
         OP_STATUS: ;
         default:   ans.ok = 1'b0;
      endcase
      ans.stored_count  = ptr_gap(wr_ptr, rd_ptr);
      ans.dripped_count = ptr_gap(drip_ptr, wr_ptr);
      ans.peeked_count  = ptr_gap(peek_ptr, rd_ptr);
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] response %0d: %s expected %0d, got %0d",
                  $time, responses_checked, what, want, got);
   endtask

   // Present one request, hold it until accepted, then record the expected response.
   // Entered and left at a rising edge.
   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] data);
      int              gap;
      bit              hazard;
      fifo_answer_type ans;
      // turn a read of a never-written slot into a status request
      hazard = 1'b0;
      if ((op == OP_POP || op == OP_PEEK_HEAD) && ptr_gap(wr_ptr, rd_ptr) != 0)
         hazard = !shadow_written[rd_ptr[ADDR_W-1:0]];
      if (op == OP_PEEK_BYTE && ptr_gap(wr_ptr, peek_ptr) != 0)
         hazard = !shadow_written[peek_ptr[ADDR_W-1:0]];
      if (hazard) op = OP_STATUS;
      // close the burst with a gap and draw the next burst length
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 10);
      end
      start         <= 1'b1;
      req_opcode    <= op;
      req_data_byte <= data;
      do @(posedge clock); while (busy !== 1'b0);
      ans = apply_fifo_op(op, data);
      pending_answers.push_back(ans);
      requests_sent++;
      if (!ans.ok) refusals_predicted++;
      burst_left--;
   endtask

   // Sample responses at the rising edge, compare at the following falling edge
   always begin : response_check
      logic            seen;
      fifo_answer_type got;
      fifo_answer_type want;
      @(posedge clock);
      if (!reset && $isunknown(rsp_valid)) report_mismatch("rsp_valid unknown", 0, rsp_valid);
      seen = !reset && rsp_valid === 1'b1;
      got  = {rsp_ok, rsp_read_byte, rsp_stored_count, rsp_dripped_count, rsp_peeked_count};
      @(negedge clock);
      if (seen) begin
         responses_checked++;
         if (pending_answers.size() == 0) begin
            report_mismatch("response with no request pending", 0, 1);
         end else begin
            want = pending_answers.pop_front();
            if (got.ok !== want.ok)
               report_mismatch("ok", want.ok, got.ok);
            if (got.read_byte !== want.read_byte)
               report_mismatch("read_byte", want.read_byte, got.read_byte);
            if (got.stored_count !== want.stored_count)
               report_mismatch("stored_count", want.stored_count, got.stored_count);
            if (got.dripped_count !== want.dripped_count)
               report_mismatch("dripped_count", want.dripped_count, got.dripped_count);
            if (got.peeked_count !== want.peeked_count)
               report_mismatch("peeked_count", want.peeked_count, got.peeked_count);
         end
      end
   end

   // Refusals on an empty FIFO, extreme bytes, undefined opcodes
   task automatic test_empty_and_unknown();
      // every read of an empty FIFO is refused
      send_request(OP_STATUS, 8'h00);
      send_request(OP_POP, 8'hFF);
      send_request(OP_PEEK_HEAD, 8'h00);
      send_request(OP_PEEK_BYTE, 8'hFF);
      // carry both extreme byte values through the store
      send_request(OP_PUSH, 8'h00);
      send_request(OP_PUSH, 8'hFF);
      send_request(OP_PEEK_HEAD, 8'h00);
      send_request(OP_POP, 8'h00);
      send_request(OP_POP, 8'h00);
      send_request(OP_POP, 8'h00);
      // undefined opcodes change nothing and answer with ok low
      for (int code = OP_STATUS + 1; code < (1 << OPCODE_W); code++)
         send_request(OPCODE_W'(code), 8'hA5);
   endtask

   // Speculative pointers used out of order; counts must stay modular
   task automatic test_pointer_order();
      send_request(OP_PUSH, 8'h5A);
      send_request(OP_DRIP_START, 8'h00);
      send_request(OP_DRIP_BYTE, 8'hC3);
      send_request(OP_DRIP_BYTE, 8'h81);
      // a push under an open drip overwrites a dripped slot
      send_request(OP_PUSH, 8'h3C);
      send_request(OP_DRIP_COMMIT, 8'h00);
      // pop past the peek pointer so the peeked count wraps
      send_request(OP_PEEK_START, 8'h00);
      send_request(OP_POP, 8'h00);
      send_request(OP_PEEK_BYTE, 8'h00);
      send_request(OP_PEEK_REMOVE, 8'h00);
      send_request(OP_FLUSH, 8'h00);
      // a stale drip pointer pulls the write pointer back
      send_request(OP_PUSH, 8'h11);
      send_request(OP_DRIP_COMMIT, 8'h00);
   endtask

   // Full FIFO through both write paths
   task automatic test_fill_to_full();
      int room;
      // push until full, then two refused pushes
      while (ptr_gap(wr_ptr, rd_ptr) != DEPTH)
         send_request(OP_PUSH, rand_byte());
      repeat (2) send_request(OP_PUSH, rand_byte());
      // a drip into a full FIFO is refused at once
      send_request(OP_DRIP_START, 8'h00);
      send_request(OP_DRIP_BYTE, rand_byte());
      // free some room and fill it again with one drip transaction
      room = $urandom_range(8, 20);
      repeat (room) send_request(OP_POP, 8'h00);
      send_request(OP_DRIP_START, 8'h00);
      while (ptr_gap(drip_ptr, rd_ptr) != DEPTH)
         send_request(OP_DRIP_BYTE, rand_byte());
      send_request(OP_DRIP_BYTE, rand_byte());
      send_request(OP_DRIP_COMMIT, 8'h00);
      // read part of it speculatively and drop what was read
      send_request(OP_PEEK_START, 8'h00);
      repeat (room) send_request(OP_PEEK_BYTE, 8'h00);
      send_request(OP_PEEK_REMOVE, 8'h00);
   endtask

   // Mostly well-formed transactions with random content, some broken ones and noise
   task automatic test_random_mix();
      int first_request;
      int kind;
      int n;
      first_request = requests_sent;
      while (requests_sent - first_request < MIX_REQUESTS) begin
         kind = $urandom_range(0, 11);
         n    = $urandom_range(1, 12);
         case (kind)
            0, 1, 2: begin
               repeat (n) send_request(OP_PUSH, rand_byte());
            end
            3, 4: begin
               repeat (n) send_request(OP_POP, rand_byte());
            end
            5, 6: begin
               send_request(OP_DRIP_START, rand_byte());
               repeat (n - 1) begin
                  // now and then slip a plain push into the transaction
                  if ($urandom_range(0, 15) == 0)
                     send_request(OP_PUSH, rand_byte());
                  send_request(OP_DRIP_BYTE, rand_byte());
               end
               if ($urandom_range(0, 7) != 0)
                  send_request(OP_DRIP_COMMIT, rand_byte());
            end
            7, 8: begin
               send_request(OP_PEEK_START, rand_byte());
               repeat (n - 1) send_request(OP_PEEK_BYTE, rand_byte());
               if ($urandom_range(0, 3) != 0)
                  send_request(OP_PEEK_REMOVE, rand_byte());
            end
            9: begin
               case ($urandom_range(0, 2))
                  0:       send_request(OP_PEEK_HEAD, rand_byte());
                  1:       send_request(OP_STATUS, rand_byte());
                  default: send_request(OP_FLUSH, rand_byte());
               endcase
            end
            default: begin
               repeat ((n + 1) / 2)
                  send_request(OPCODE_W'($urandom_range(0, (1 << OPCODE_W) - 1)),
                               rand_byte());
            end
         endcase
      end
   endtask

   initial begin
      reset         <= 1'b1;
      start         <= 1'b0;
      req_opcode    <= OP_STATUS;
      req_data_byte <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_unknown();
      test_pointer_order();
      test_fill_to_full();
      test_random_mix();
      start <= 1'b0;

      // let every outstanding response arrive, then watch for strays
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d refused by design) across empty, ordering, full",
               requests_sent, refusals_predicted);
      $display("and mixed transaction phases; %0d responses checked, %0d mismatches",
               responses_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[byte_fifo_with_commit_pointers.f]
hdl/bfcp_pkg.sv
hdl/bfcp_store.sv
hdl/bfcp_ctrl.sv
hdl/byte_fifo_with_commit_pointers.sv
tb/tb_byte_fifo_with_commit_pointers.sv
